>>> rtl/core/tsst_pkg.sv
// tsst_pkg: types and constants shared by the tcp session set tracker
// holds header, result and table entry layouts; no dependencies
package tsst_pkg;

    localparam logic [15:0] IPV4_FRAME = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;

    localparam logic [7:0] TH_FIN  = 8'h01;
    localparam logic [7:0] TH_SYN  = 8'h02;
    localparam logic [7:0] TH_RST  = 8'h04;
    localparam logic [7:0] TH_PUSH = 8'h08;
    localparam logic [7:0] TH_ACK  = 8'h10;
    localparam logic [7:0] TH_URG  = 8'h20;

    localparam int KEY_W = 34;

    typedef enum logic [2:0] {
        ACT_NON_IP   = 3'd0,
        ACT_NON_TCP  = 3'd1,
        ACT_INSERTED = 3'd2,
        ACT_PRESENT  = 3'd3,
        ACT_REMOVED  = 3'd4,
        ACT_ABSENT   = 3'd5,
        ACT_NOOP     = 3'd6,
        ACT_FULL     = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_COMMIT,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [7:0]  tcp_flags;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [7:0]  ip_protocol;
        logic [15:0] frame_kind;
    } t_hdr;

    typedef struct packed {
        logic [31:0] packet_total;
        logic [6:0]  session_count;
        t_action     action_code;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_entry;

endpackage

>>> rtl/core/tcp_session_set_tracker_core.sv
// tcp session set tracker: one result per packet header transaction, one packet in flight
// non-ip, non-tcp and no-op packets skip the table; insert/remove packets first scan the
// whole table, one entry per cycle, then commit the set update before the result goes out
// reset: synchronous, active low; a clearing pass over all TABLE_ENTRIES entries follows
// with s_axis tready low; depends on tsst_pkg, tsst_ctrl, tsst_key_mem
module tcp_session_set_tracker_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // frame_kind[15:0] ip_protocol[23:16] src_addr[55:24] dst_addr[87:56]
    // src_port[103:88] dst_port[119:104] tcp_flags[127:120]
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // action_code[2:0] session_count[9:3] packet_total[41:10], zeros above
    output logic [47:0]  o_m_axis_tdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    tsst_pkg::t_hdr    hdr;
    tsst_pkg::t_result res;
    logic              res_valid;
    logic              res_ready;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    tsst_pkg::t_entry  wr_data;
    tsst_pkg::t_entry  rd_data;

    logic              r_out_valid;
    tsst_pkg::t_result r_out;

    assign hdr = tsst_pkg::t_hdr'(i_s_axis_tdata);

    tsst_ctrl #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_hdr       (hdr),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data)
    );

    tsst_key_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // output register frees the core while a result waits downstream
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out};

endmodule

>>> rtl/core/tsst_key_mem.sv
// tsst_key_mem: single-port-write, registered-read key table memory
// entries are tsst_pkg::t_entry (valid bit plus session key)
module tsst_key_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  tsst_pkg::t_entry  i_wr_data,
    output tsst_pkg::t_entry  o_rd_data
);

    tsst_pkg::t_entry r_mem [DEPTH];
    tsst_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/tsst_ctrl.sv
// tsst_ctrl: packet classification, table scan sequencer and set update
// uses tsst_pkg types; drives the ports of tsst_key_mem
module tsst_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tsst_pkg::t_hdr    i_hdr,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output tsst_pkg::t_result o_res,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output tsst_pkg::t_entry  o_wr_data,
    input  tsst_pkg::t_entry  i_rd_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    tsst_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_chk_v, n_chk_v;
    logic [AW-1:0]    r_chk_idx, n_chk_idx;
    logic [tsst_pkg::KEY_W-1:0] r_key, n_key;
    logic             r_is_ins, n_is_ins;
    logic             r_hit, n_hit;
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    logic             r_free, n_free;
    logic [AW-1:0]    r_free_idx, n_free_idx;
    logic [CW-1:0]    r_live, n_live;
    logic [31:0]      r_pkts, n_pkts;
    tsst_pkg::t_result r_res, n_res;

    logic [7:0]       flags;
    logic             want_ins;
    logic             want_rem;

    assign flags    = i_hdr.tcp_flags;
    assign want_ins = ((flags & (tsst_pkg::TH_SYN | tsst_pkg::TH_ACK))
                          == (tsst_pkg::TH_SYN | tsst_pkg::TH_ACK))
                   || ((flags & (tsst_pkg::TH_PUSH | tsst_pkg::TH_ACK))
                          == (tsst_pkg::TH_PUSH | tsst_pkg::TH_ACK))
                   || ((flags & (tsst_pkg::TH_URG | tsst_pkg::TH_ACK))
                          == (tsst_pkg::TH_URG | tsst_pkg::TH_ACK));
    assign want_rem = (flags & (tsst_pkg::TH_FIN | tsst_pkg::TH_RST)) != 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsst_pkg::S_CLEAR;
            r_idx   <= '0;
            r_chk_v <= 1'b0;
            r_live  <= '0;
            r_pkts  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_chk_v <= n_chk_v;
            r_live  <= n_live;
            r_pkts  <= n_pkts;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_key      <= n_key;
        r_is_ins   <= n_is_ins;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_chk_v    = (r_state == tsst_pkg::S_SCAN);
        n_chk_idx  = r_idx;
        n_key      = r_key;
        n_is_ins   = r_is_ins;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_live     = r_live;
        n_pkts     = r_pkts;
        n_res      = r_res;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_idx;
        o_wr_data   = '0;

        // check the entry read in the previous cycle
        if (r_chk_v) begin
            if (i_rd_data.valid && (i_rd_data.key == r_key) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_chk_idx;
            end
            // lowest free entry wins
            if (!i_rd_data.valid && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_chk_idx;
            end
        end

        unique case (r_state)
            tsst_pkg::S_CLEAR: begin
                o_wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = tsst_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            tsst_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_pkts != 32'hFFFF_FFFF) begin
                        n_pkts = r_pkts + 32'd1;
                    end
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    n_idx  = '0;
                    n_key  = tsst_pkg::KEY_W'({2'b00, i_hdr.src_addr})
                           + tsst_pkg::KEY_W'({2'b00, i_hdr.dst_addr})
                           + tsst_pkg::KEY_W'({18'd0, i_hdr.src_port})
                           + tsst_pkg::KEY_W'({18'd0, i_hdr.dst_port});
                    n_is_ins = want_ins;
                    n_res.session_count = 7'(r_live);
                    n_res.packet_total  = n_pkts;
                    n_res.action_code   = tsst_pkg::ACT_NOOP;
                    n_state             = tsst_pkg::S_PUSH;
                    if (i_hdr.frame_kind != tsst_pkg::IPV4_FRAME) begin
                        n_res.action_code = tsst_pkg::ACT_NON_IP;
                    end else if (i_hdr.ip_protocol != tsst_pkg::PROTO_TCP) begin
                        n_res.action_code = tsst_pkg::ACT_NON_TCP;
                    end else if (want_ins || want_rem) begin
                        n_state = tsst_pkg::S_SCAN;
                    end
                end
            end
            tsst_pkg::S_SCAN: begin
                o_rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = tsst_pkg::S_LAST;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            tsst_pkg::S_LAST: begin
                n_state = tsst_pkg::S_COMMIT;
            end
            tsst_pkg::S_COMMIT: begin
                n_state = tsst_pkg::S_PUSH;
                if (r_is_ins) begin
                    if (r_hit) begin
                        n_res.action_code = tsst_pkg::ACT_PRESENT;
                    end else if (r_free) begin
                        o_wr_en         = 1'b1;
                        o_wr_addr       = r_free_idx;
                        o_wr_data.valid = 1'b1;
                        o_wr_data.key   = r_key;
                        n_live          = r_live + CW'(1);
                        n_res.action_code = tsst_pkg::ACT_INSERTED;
                    end else begin
                        n_res.action_code = tsst_pkg::ACT_FULL;
                    end
                end else begin
                    if (r_hit) begin
                        o_wr_en         = 1'b1;
                        o_wr_addr       = r_hit_idx;
                        o_wr_data.valid = 1'b0;
                        o_wr_data.key   = r_key;
                        if (r_live != '0) begin
                            n_live = r_live - CW'(1);
                        end
                        n_res.action_code = tsst_pkg::ACT_REMOVED;
                    end else begin
                        n_res.action_code = tsst_pkg::ACT_ABSENT;
                    end
                end
                n_res.session_count = 7'(n_live);
            end
            tsst_pkg::S_PUSH: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = tsst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsst_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

>>> tb/tcp_session_set_tracker_core_tb.sv
// testbench for tcp_session_set_tracker_core: drives header transactions, predicts
// the session set and checks every result; depends on tsst_pkg and the core rtl
module tcp_session_set_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 64;
    localparam int FLOW_POOL     = 96;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        tsst_pkg::t_hdr hdr;
        logic [3:0]     pause;
        logic           wait_drain;
    } t_pkt_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic [127:0] s_data;
    logic         m_ready;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [47:0]  o_m_axis_tdata;

    // stimulus, expected results and predictor state
    t_pkt_item                  pkt_queue[$];
    tsst_pkg::t_result          results_due[$];
    logic [tsst_pkg::KEY_W-1:0] slot_key[TABLE_ENTRIES];
    logic                       slot_used[TABLE_ENTRIES];
    logic [6:0]                 live_count;
    logic [31:0]                pkt_total;

    int unsigned sent_cnt;
    int unsigned got_cnt;
    int unsigned mismatches;
    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned idle_cycles;
    int unsigned hold_cnt;
    bit          hold_on;
    bit          hold_done;
    bit          sender_calm;
    bit          recv_calm;
    bit          drain_next;

    logic [31:0] pool_src[FLOW_POOL];
    logic [31:0] pool_dst[FLOW_POOL];
    logic [15:0] pool_sport[FLOW_POOL];
    logic [15:0] pool_dport[FLOW_POOL];

    tcp_session_set_tracker_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic tsst_pkg::t_hdr make_hdr(input logic [15:0] kind,
                                                input logic [7:0] proto,
                                                input logic [31:0] src, input logic [31:0] dst,
                                                input logic [15:0] sport,
                                                input logic [15:0] dport,
                                                input logic [7:0] flags);
        tsst_pkg::t_hdr h;
        h.frame_kind  = kind;
        h.ip_protocol = proto;
        h.src_addr    = src;
        h.dst_addr    = dst;
        h.src_port    = sport;
        h.dst_port    = dport;
        h.tcp_flags   = flags;
        return h;
    endfunction

    function automatic void add_pkt(input tsst_pkg::t_hdr h);
        t_pkt_item it;
        it.hdr        = h;
        it.pause      = sender_calm ? 4'd0 : 4'($urandom_range(0, 7));
        it.wait_drain = drain_next;
        drain_next    = 1'b0;
        pkt_queue.push_back(it);
    endfunction

    function automatic bit has_pair(input logic [7:0] flags, input logic [7:0] pair);
        return (flags & pair) == pair;
    endfunction

    // session set update for one accepted header, queues the result it should give
    function automatic void track_packet(input tsst_pkg::t_hdr h);
        logic [tsst_pkg::KEY_W-1:0] sess_key;
        tsst_pkg::t_action          act;
        tsst_pkg::t_result          r;
        int                         hit;
        int                         free_slot;
        hit       = -1;
        free_slot = -1;
        if (pkt_total != 32'hFFFF_FFFF)
            pkt_total = pkt_total + 32'd1;
        if (h.frame_kind != tsst_pkg::IPV4_FRAME) begin
            act = tsst_pkg::ACT_NON_IP;
        end else if (h.ip_protocol != tsst_pkg::PROTO_TCP) begin
            act = tsst_pkg::ACT_NON_TCP;
        end else begin
            sess_key = {2'b00, h.src_addr} + {2'b00, h.dst_addr}
                     + {18'd0, h.src_port} + {18'd0, h.dst_port};
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (hit < 0 && slot_used[i] && slot_key[i] == sess_key)
                    hit = i;
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            end
            if (has_pair(h.tcp_flags, tsst_pkg::TH_SYN | tsst_pkg::TH_ACK)
                    || has_pair(h.tcp_flags, tsst_pkg::TH_PUSH | tsst_pkg::TH_ACK)
                    || has_pair(h.tcp_flags, tsst_pkg::TH_URG | tsst_pkg::TH_ACK)) begin
                if (hit >= 0) begin
                    act = tsst_pkg::ACT_PRESENT;
                end else if (free_slot < 0) begin
                    act = tsst_pkg::ACT_FULL;
                end else begin
                    slot_key[free_slot]  = sess_key;
                    slot_used[free_slot] = 1'b1;
                    live_count           = live_count + 7'd1;
                    act                  = tsst_pkg::ACT_INSERTED;
                end
            end else if ((h.tcp_flags & (tsst_pkg::TH_FIN | tsst_pkg::TH_RST)) != 8'd0) begin
                if (hit < 0) begin
                    act = tsst_pkg::ACT_ABSENT;
                end else begin
                    slot_used[hit] = 1'b0;
                    if (live_count != 7'd0)
                        live_count = live_count - 7'd1;
                    act = tsst_pkg::ACT_REMOVED;
                end
            end else begin
                act = tsst_pkg::ACT_NOOP;
            end
        end
        r.action_code   = act;
        r.session_count = live_count;
        r.packet_total  = pkt_total;
        results_due.push_back(r);
    endfunction

    function automatic void check_result(input logic [47:0] word);
        tsst_pkg::t_result got;
        tsst_pkg::t_result want;
        got = word[41:0];
        if (results_due.size() == 0) begin
            if (mismatches < MAX_REPORTS)
                $display("unexpected result: action %0d count %0d total %0d",
                         got.action_code, got.session_count, got.packet_total);
            mismatches++;
        end else begin
            want = results_due.pop_front();
            if (got.action_code !== want.action_code
                    || got.session_count !== want.session_count
                    || got.packet_total !== want.packet_total || word[47:42] !== 6'd0) begin
                if (mismatches < MAX_REPORTS)
                    $display("mismatch: exp act %0d cnt %0d tot %0d / got act %0d cnt %0d tot %0d pad %h",
                             want.action_code, want.session_count, want.packet_total,
                             got.action_code, got.session_count, got.packet_total, word[47:42]);
                mismatches++;
            end
        end
    endfunction

    // driver: one header transaction at a time, pause before each taken from its item
    always @(posedge i_clk) begin
        logic      nv;
        t_pkt_item it;
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            sent_cnt <= 0;
            send_gap = 0;
        end else begin
            nv = s_valid;
            if (s_valid && o_s_axis_tready) begin
                track_packet(tsst_pkg::t_hdr'(s_data));
                sent_cnt <= sent_cnt + 1;
                nv = 1'b0;
                send_gap = (pkt_queue.size() != 0) ? pkt_queue[0].pause : 0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pkt_queue.size() != 0
                             && !(pkt_queue[0].wait_drain && results_due.size() != 0)) begin
                    it = pkt_queue.pop_front();
                    s_data <= it.hdr;
                    nv = 1'b1;
                end
            end
            s_valid <= nv;
        end
    end

    // monitor: random stall per result, plus the long hold below
    always @(posedge i_clk) begin
        logic nr;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            got_cnt <= 0;
            recv_stall = 0;
        end else begin
            nr = m_ready;
            if (m_ready && o_m_axis_tvalid) begin
                check_result(o_m_axis_tdata);
                got_cnt <= got_cnt + 1;
                nr = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    recv_calm = !recv_calm;
                recv_stall = recv_calm ? 0 : $urandom_range(0, 7);
            end
            if (!nr && !hold_on) begin
                if (recv_stall > 0)
                    recv_stall--;
                else
                    nr = 1'b1;
            end
            if (hold_on)
                nr = 1'b0;
            m_ready <= nr;
        end
    end

    // one long receiver hold so the core backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_on   <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end else if (hold_on) begin
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_on   <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end else if (!hold_done && got_cnt >= HOLD_AFTER) begin
            hold_on  <= 1'b1;
            hold_cnt <= 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_valid && o_s_axis_tready) || (m_ready && o_m_axis_tvalid)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          roll;
        int          idx;
        int          ins_top[4];
        logic [31:0] a;
        logic [31:0] b;
        logic [15:0] pa;
        logic [15:0] pb;
        logic [7:0]  fl;
        logic [15:0] et;
        logic [7:0]  pr;
        logic [7:0]  pairs[3];

        i_rst_n     = 1'b0;
        mismatches  = 0;
        live_count  = '0;
        pkt_total   = '0;
        sender_calm = 1'b0;
        recv_calm   = 1'b0;
        drain_next  = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
        end
        pairs[0]   = tsst_pkg::TH_SYN | tsst_pkg::TH_ACK;
        pairs[1]   = tsst_pkg::TH_PUSH | tsst_pkg::TH_ACK;
        pairs[2]   = tsst_pkg::TH_URG | tsst_pkg::TH_ACK;
        ins_top[0] = 85;
        ins_top[1] = 50;
        ins_top[2] = 85;
        ins_top[3] = 30;

        // directed: filter paths, extremes, flag pairs, slot reuse, 34-bit key carry
        add_pkt(make_hdr(16'h0000, tsst_pkg::PROTO_TCP, '1, '1, '1, '1,
                         tsst_pkg::TH_SYN | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(16'hFFFF, tsst_pkg::PROTO_TCP, 0, 0, 0, 0, 8'hFF));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, 8'hFF, '1, '1, '1, '1, 8'hFF));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, 8'h00, 0, 0, 0, 0, tsst_pkg::TH_FIN));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 32'h0A00_0001,
                         32'h0A00_0002, 80, 1234, 8'h00));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, '1, '1, '1, '1, 8'hFF));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, '1, '1, '1, '1,
                         tsst_pkg::TH_SYN | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, '1, '1, '1, '1,
                         tsst_pkg::TH_PUSH | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, '1, '1, '1, '1,
                         tsst_pkg::TH_FIN));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, '1, '1, '1, '1,
                         tsst_pkg::TH_RST));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 0, 0, 0, 0,
                         tsst_pkg::TH_URG | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 0, 1, 0, 0,
                         tsst_pkg::TH_SYN | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 0, 0, 0, 0,
                         tsst_pkg::TH_FIN | tsst_pkg::TH_RST));
        // freed lowest slot takes the next new key
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 2, 1, 1, 1,
                         tsst_pkg::TH_SYN | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 1, 2, 1, 1,
                         tsst_pkg::TH_FIN | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 5, 0, 0, 0,
                         tsst_pkg::TH_SYN));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 5, 0, 0, 0,
                         tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 5, 0, 0, 0,
                         tsst_pkg::TH_PUSH | tsst_pkg::TH_URG));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 0, 1, 0, 0,
                         tsst_pkg::TH_FIN | tsst_pkg::TH_SYN));
        // carry into bit 32 keeps this apart from key zero
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, '1, 1, 0, 0,
                         tsst_pkg::TH_SYN | tsst_pkg::TH_ACK));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 0, 0, 0, 0,
                         tsst_pkg::TH_RST));
        add_pkt(make_hdr(tsst_pkg::IPV4_FRAME, tsst_pkg::PROTO_TCP, 32'h8000_0000,
                         32'h8000_0000, 16'h8000, 16'h8000,
                         tsst_pkg::TH_URG | tsst_pkg::TH_ACK | tsst_pkg::TH_FIN));

        for (int i = 0; i < FLOW_POOL; i++) begin
            pool_src[i]   = $urandom;
            pool_dst[i]   = $urandom;
            pool_sport[i] = 16'($urandom_range(0, 65535));
            pool_dport[i] = 16'($urandom_range(0, 65535));
        end

        // random: fill, churn, fill, drain over a flow pool larger than the table
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 285; n++) begin
                if (n % 100 == 0)
                    sender_calm = ($urandom_range(0, 2) == 0);
                if (ph == 2 && n == 0)
                    drain_next = 1'b1;
                idx = $urandom_range(0, FLOW_POOL - 1);
                // either direction of a flow gives the same key
                if ($urandom_range(0, 1)) begin
                    a  = pool_src[idx];
                    b  = pool_dst[idx];
                    pa = pool_sport[idx];
                    pb = pool_dport[idx];
                end else begin
                    a  = pool_dst[idx];
                    b  = pool_src[idx];
                    pa = pool_dport[idx];
                    pb = pool_sport[idx];
                end
                et   = tsst_pkg::IPV4_FRAME;
                pr   = tsst_pkg::PROTO_TCP;
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    et = 16'($urandom_range(0, 65535));
                    if (et == tsst_pkg::IPV4_FRAME)
                        et = et ^ 16'h0001;
                    pr = 8'($urandom_range(0, 255));
                    fl = 8'($urandom_range(0, 255));
                end else if (roll < 10) begin
                    pr = 8'($urandom_range(0, 255));
                    if (pr == tsst_pkg::PROTO_TCP)
                        pr = pr ^ 8'h80;
                    fl = 8'($urandom_range(0, 255));
                end else if (roll < ins_top[ph]) begin
                    fl = pairs[$urandom_range(0, 2)] | 8'($urandom_range(0, 255));
                end else if (roll < 95) begin
                    fl = 8'($urandom_range(0, 255)) & ~tsst_pkg::TH_ACK;
                    case ($urandom_range(0, 2))
                        0: fl = fl | tsst_pkg::TH_FIN;
                        1: fl = fl | tsst_pkg::TH_RST;
                        default: fl = fl | tsst_pkg::TH_FIN | tsst_pkg::TH_RST;
                    endcase
                end else begin
                    fl = 8'($urandom_range(0, 255))
                       & ~(tsst_pkg::TH_FIN | tsst_pkg::TH_RST | tsst_pkg::TH_ACK);
                end
                add_pkt(make_hdr(et, pr, a, b, pa, pb, fl));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pkt_queue.size() != 0 || s_valid || sent_cnt != got_cnt)
            @(negedge i_clk);
        // room for a late stray result from a table scan
        repeat (TABLE_ENTRIES + 16) @(negedge i_clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tsst_pkg.sv
rtl/core/tsst_key_mem.sv
rtl/core/tsst_ctrl.sv
rtl/core/tcp_session_set_tracker_core.sv
tb/tcp_session_set_tracker_core_tb.sv
